// ===== hdl/mer_pkg.sv =====
// Shared types and constants for the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

	// Width of every output coordinate; results wrap modulo 2^OUT_W.
	localparam int OUT_W = 12;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_CMP1,
		ST_CMP2,
		ST_CHK,
		ST_R1_M1,
		ST_R1_M2,
		ST_R1_M3,
		ST_R2I_1,
		ST_R2I_2,
		ST_R2I_3,
		ST_R2I_4,
		ST_R2I_5,
		ST_R2_UPD,
		ST_R2_M1,
		ST_R2_M2,
		ST_R2_M3,
		ST_EMIT
	} state_t;

	// Destination register of one multiply-accumulate operation.
	typedef enum logic [2:0] {
		DST_NONE,
		DST_TMP,
		DST_DEC,
		DST_RX2,
		DST_RY2
	} dst_t;

	typedef enum logic [2:0] {
		A_RX,
		A_RY,
		A_RX2,
		A_RY2,
		A_ODDX,
		A_YM1
	} asel_t;

	typedef enum logic [3:0] {
		B_RX,
		B_RY,
		B_OX,
		B_OY,
		B_ODDX,
		B_YM1,
		B_TMP,
		B_ONE,
		B_RY2
	} bsel_t;

	// The encoding is the left shift applied to the product.
	typedef enum logic [1:0] {
		SH_X1 = 2'd0,
		SH_X4 = 2'd2,
		SH_X8 = 2'd3
	} shift_t;

	typedef struct packed {
		dst_t   dst;
		logic   clr;
		logic   neg;
		shift_t sh;
		asel_t  asel;
		bsel_t  bsel;
	} mac_op_t;

	localparam mac_op_t MAC_NOP = '{DST_NONE, 1'b0, 1'b0, SH_X1, A_RX, B_ONE};

endpackage

`default_nettype wire

// ===== hdl/midpoint_ellipse_rasterizer_unit.sv =====
// Top level of the midpoint ellipse rasterizer with its sequencer and multiply-accumulate unit.
`default_nettype none

// The block walks the first-quadrant arc of an axis-aligned ellipse with the two-region
// midpoint method and returns, for each input transfer, one result transfer holding the
// four mirrored pixel coordinates of the current point. An input with action 0 loads the
// center and radii and returns the top point; an input with action 1 advances one point.
// When the walk is finished (y offset zero), further advances return the last point again
// with last_point set. Decision values are exact integers, four times the textbook values.
// All arithmetic runs through one multiply-accumulate unit under a small sequencer, so one
// item is worked on at a time and in_stall stays high until its result is registered.
// The length of each update is set by the multiply-accumulate operations it needs, at
// most one per sequencer state; the step that crosses into region two also rebuilds the
// decision value, and an advance on a finished walk only returns its result. A new
// input can be accepted while the previous result still waits on out_stall; the result
// register only blocks the sequencer at its final load.
module midpoint_ellipse_rasterizer_unit #(
	parameter int COORD_BITS  = 10,
	parameter int RADIUS_BITS = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [COORD_BITS-1:0]             center_x,
	input  logic [COORD_BITS-1:0]             center_y,
	input  logic [RADIUS_BITS-1:0]            radius_x,
	input  logic [RADIUS_BITS-1:0]            radius_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mer_pkg::OUT_W-1:0]  right_x,
	output logic signed [mer_pkg::OUT_W-1:0]  left_x,
	output logic signed [mer_pkg::OUT_W-1:0]  top_y,
	output logic signed [mer_pkg::OUT_W-1:0]  bottom_y,
	output logic                              last_point
);
	import mer_pkg::*;

	// Offsets need one bit above the radius since x may pass rx by one.
	localparam int OW = RADIUS_BITS + 1;
	// Multiplier operand A holds squared radii; operand B also holds (2x+1)^2.
	localparam int AW = 2 * RADIUS_BITS;
	localparam int BW = 2 * RADIUS_BITS + 4;
	localparam int PW = AW + BW;
	// Decision accumulator: product, shift by up to eight, and a sign bit.
	localparam int DW = PW + 4;

	state_t state_q, state_d;

	logic [COORD_BITS-1:0]  cx_q, cy_q;
	logic [RADIUS_BITS-1:0] rx_q, ry_q;
	logic [AW-1:0]          rx2_q, ry2_q;
	logic [OW-1:0]          ox_q, oy_q;
	logic                   r2_q;
	logic                   br_q;
	logic [DW-1:0]          tmp_q, dec_q;

	logic                   out_valid_q;
	logic [OUT_W-1:0]       right_x_q, left_x_q, top_y_q, bottom_y_q;
	logic                   last_point_q;

	mac_op_t mac;
	logic    ld_start, step_r1, step_r2, set_r2, emit_ld;

	logic          in_xfer, out_free, oy_zero;
	logic [OW:0]   odd_x;
	logic [OW-1:0] y_m1;
	logic          dec_neg, dec_le0, tmp_gt0;

	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [DW-1:0] term_u, term, base, mac_sum;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The walk is finished exactly when the y offset is zero.
	assign oy_zero = (oy_q == '0);
	assign odd_x   = {ox_q, 1'b1};
	assign y_m1    = oy_q - OW'(1);

	assign dec_neg = dec_q[DW-1];
	assign dec_le0 = dec_neg || (dec_q == '0);
	// Positive means ry^2*x > rx^2*y, the point where region two begins.
	assign tmp_gt0 = !tmp_q[DW-1] && (tmp_q != '0);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (mac.asel)
			A_RX:    mul_a = AW'(rx_q);
			A_RY:    mul_a = AW'(ry_q);
			A_RX2:   mul_a = rx2_q;
			A_RY2:   mul_a = ry2_q;
			A_ODDX:  mul_a = AW'(odd_x);
			A_YM1:   mul_a = AW'(y_m1);
			default: mul_a = '0;
		endcase
	end

	always_comb begin
		case (mac.bsel)
			B_RX:    mul_b = BW'(rx_q);
			B_RY:    mul_b = BW'(ry_q);
			B_OX:    mul_b = BW'(ox_q);
			B_OY:    mul_b = BW'(oy_q);
			B_ODDX:  mul_b = BW'(odd_x);
			B_YM1:   mul_b = BW'(y_m1);
			B_TMP:   mul_b = tmp_q[BW-1:0];
			B_ONE:   mul_b = BW'(1);
			B_RY2:   mul_b = BW'(ry2_q);
			default: mul_b = '0;
		endcase
	end

	// One multiply, a selectable shift, an optional negation and one accumulate per cycle.
	assign prod    = PW'(mul_a) * PW'(mul_b);
	assign term_u  = DW'(prod) << mac.sh;
	assign term    = mac.neg ? (~term_u + DW'(1)) : term_u;
	assign base    = mac.clr ? '0 : ((mac.dst == DST_TMP) ? tmp_q : dec_q);
	assign mac_sum = base + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: each state issues at most one multiply-accumulate operation.
	always_comb begin
		state_d  = state_q;
		mac      = MAC_NOP;
		ld_start = 1'b0;
		step_r1  = 1'b0;
		step_r2  = 1'b0;
		set_r2   = 1'b0;
		emit_ld  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (!action) begin
						ld_start = 1'b1;
						state_d  = ST_SQX;
					end else if (oy_zero) begin
						state_d = ST_EMIT;
					end else if (r2_q) begin
						state_d = ST_R2_UPD;
					end else begin
						state_d = ST_CMP1;
					end
				end
			end
			ST_SQX: begin
				mac     = '{DST_RX2, 1'b1, 1'b0, SH_X1, A_RX, B_RX};
				state_d = ST_SQY;
			end
			ST_SQY: begin
				mac     = '{DST_RY2, 1'b1, 1'b0, SH_X1, A_RY, B_RY};
				state_d = ST_D1;
			end
			ST_D1: begin
				mac     = '{DST_DEC, 1'b1, 1'b1, SH_X4, A_RX2, B_RY};
				state_d = ST_D2;
			end
			ST_D2: begin
				mac     = '{DST_DEC, 1'b0, 1'b0, SH_X4, A_RY2, B_ONE};
				state_d = ST_D3;
			end
			ST_D3: begin
				mac     = '{DST_DEC, 1'b0, 1'b0, SH_X1, A_RX2, B_ONE};
				state_d = ST_EMIT;
			end
			ST_CMP1: begin
				mac     = '{DST_TMP, 1'b1, 1'b0, SH_X1, A_RY2, B_OX};
				state_d = ST_CMP2;
			end
			ST_CMP2: begin
				mac     = '{DST_TMP, 1'b0, 1'b1, SH_X1, A_RX2, B_OY};
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (tmp_gt0) begin
					state_d = ST_R2I_1;
				end else begin
					step_r1 = 1'b1;
					state_d = ST_R1_M1;
				end
			end
			ST_R1_M1: begin
				mac     = '{DST_DEC, 1'b0, 1'b0, SH_X8, A_RY2, B_OX};
				state_d = ST_R1_M2;
			end
			ST_R1_M2: begin
				mac     = '{DST_DEC, 1'b0, 1'b0, SH_X4, A_RY2, B_ONE};
				state_d = br_q ? ST_R1_M3 : ST_EMIT;
			end
			ST_R1_M3: begin
				mac     = '{DST_DEC, 1'b0, 1'b1, SH_X8, A_RX2, B_OY};
				state_d = ST_EMIT;
			end
			ST_R2I_1: begin
				mac     = '{DST_TMP, 1'b1, 1'b0, SH_X1, A_ODDX, B_ODDX};
				state_d = ST_R2I_2;
			end
			ST_R2I_2: begin
				mac     = '{DST_DEC, 1'b1, 1'b0, SH_X1, A_RY2, B_TMP};
				state_d = ST_R2I_3;
			end
			ST_R2I_3: begin
				mac     = '{DST_TMP, 1'b1, 1'b0, SH_X1, A_YM1, B_YM1};
				state_d = ST_R2I_4;
			end
			ST_R2I_4: begin
				mac     = '{DST_DEC, 1'b0, 1'b0, SH_X4, A_RX2, B_TMP};
				state_d = ST_R2I_5;
			end
			ST_R2I_5: begin
				mac     = '{DST_DEC, 1'b0, 1'b1, SH_X4, A_RX2, B_RY2};
				set_r2  = 1'b1;
				state_d = ST_R2_UPD;
			end
			ST_R2_UPD: begin
				step_r2 = 1'b1;
				state_d = ST_R2_M1;
			end
			ST_R2_M1: begin
				mac     = '{DST_DEC, 1'b0, 1'b1, SH_X8, A_RX2, B_OY};
				state_d = ST_R2_M2;
			end
			ST_R2_M2: begin
				mac     = '{DST_DEC, 1'b0, 1'b0, SH_X4, A_RX2, B_ONE};
				state_d = br_q ? ST_R2_M3 : ST_EMIT;
			end
			ST_R2_M3: begin
				mac     = '{DST_DEC, 1'b0, 1'b0, SH_X8, A_RY2, B_OX};
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Walk state. The center and offsets reset so that an advance after reset
	// returns the origin as a finished point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			r2_q <= 1'b0;
		end else begin
			if (ld_start) begin
				cx_q <= center_x;
				cy_q <= center_y;
				ox_q <= '0;
				oy_q <= OW'(radius_y);
				r2_q <= 1'b0;
			end
			if (step_r1) begin
				// Region one always moves right; it also moves down when D >= 0.
				ox_q <= ox_q + OW'(1);
				if (!dec_neg) begin
					oy_q <= y_m1;
				end
			end
			if (set_r2) begin
				r2_q <= 1'b1;
			end
			if (step_r2) begin
				// Region two always moves down; it also moves right when D <= 0.
				oy_q <= y_m1;
				if (dec_le0) begin
					ox_q <= ox_q + OW'(1);
				end
			end
		end
	end

	// Datapath registers; the sequencer defines them before any use.
	always_ff @(posedge clk) begin
		if (ld_start) begin
			rx_q <= radius_x;
			ry_q <= radius_y;
		end
		if (step_r1) begin
			br_q <= !dec_neg;
		end
		if (step_r2) begin
			br_q <= dec_le0;
		end
		case (mac.dst)
			DST_TMP: tmp_q <= mac_sum;
			DST_DEC: dec_q <= mac_sum;
			DST_RX2: rx2_q <= prod[AW-1:0];
			DST_RY2: ry2_q <= prod[AW-1:0];
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ld) begin
			right_x_q    <= OUT_W'(cx_q) + OUT_W'(ox_q);
			left_x_q     <= OUT_W'(cx_q) - OUT_W'(ox_q);
			top_y_q      <= OUT_W'(cy_q) + OUT_W'(oy_q);
			bottom_y_q   <= OUT_W'(cy_q) - OUT_W'(oy_q);
			last_point_q <= oy_zero;
		end
	end

	assign out_valid  = out_valid_q;
	assign right_x    = right_x_q;
	assign left_x     = left_x_q;
	assign top_y      = top_y_q;
	assign bottom_y   = bottom_y_q;
	assign last_point = last_point_q;

endmodule

`default_nettype wire

// ===== hdl/mer_checker.sv =====
// Port-level assertions for the midpoint ellipse rasterizer and their bind.
`default_nettype none

module mer_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [mer_pkg::OUT_W-1:0] right_x,
	input logic signed [mer_pkg::OUT_W-1:0] left_x,
	input logic signed [mer_pkg::OUT_W-1:0] top_y,
	input logic signed [mer_pkg::OUT_W-1:0] bottom_y,
	input logic                             last_point
);

	// An accepted item keeps the block busy for at least the next cycle.
	a_busy_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted back to back");

	// The final point has a zero y offset, so both rows coincide.
	a_last_point_rows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_point |-> top_y == bottom_y)
		else $error("last point with distinct rows");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(right_x) && $stable(left_x) &&
			$stable(top_y) && $stable(bottom_y) && $stable(last_point))
		else $error("result changed while stalled");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.right_x    (right_x),
	.left_x     (left_x),
	.top_y      (top_y),
	.bottom_y   (bottom_y),
	.last_point (last_point)
);

`default_nettype wire

// ===== sim/tb_midpoint_ellipse_rasterizer_unit.sv =====
// Self-checking testbench for the midpoint ellipse rasterizer unit.
`timescale 1ns / 1ps

module tb_midpoint_ellipse_rasterizer_unit;
	import mer_pkg::*;

	localparam int COORD_W     = 10;
	localparam int RADIUS_W    = 9;
	localparam int COORD_MAX   = (1 << COORD_W) - 1;
	localparam int RADIUS_MAX  = (1 << RADIUS_W) - 1;
	localparam int ITEM_TARGET = 1200;
	// Sender gaps and receiver stalls lengthen each transfer, and the whole run is near
	// 1300 transfers, so this bound leaves a wide margin.
	localparam int CYCLE_LIMIT = 400_000;

	// Input action codes.
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// One expected result transfer: the four mirrored coordinates and the end flag.
	typedef struct {
		logic signed [OUT_W-1:0] right_x;
		logic signed [OUT_W-1:0] left_x;
		logic signed [OUT_W-1:0] top_y;
		logic signed [OUT_W-1:0] bottom_y;
		logic                    last_point;
	} arc_point_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    action;
	logic [COORD_W-1:0]      center_x;
	logic [COORD_W-1:0]      center_y;
	logic [RADIUS_W-1:0]     radius_x;
	logic [RADIUS_W-1:0]     radius_y;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [OUT_W-1:0] right_x;
	logic signed [OUT_W-1:0] left_x;
	logic signed [OUT_W-1:0] top_y;
	logic signed [OUT_W-1:0] bottom_y;
	logic                    last_point;

	midpoint_ellipse_rasterizer_unit #(
		.COORD_BITS (COORD_W),
		.RADIUS_BITS(RADIUS_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius_x  (radius_x),
		.radius_y  (radius_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.right_x   (right_x),
		.left_x    (left_x),
		.top_y     (top_y),
		.bottom_y  (bottom_y),
		.last_point(last_point)
	);

	// Points predicted for accepted input transfers, oldest first.
	arc_point_t pending_points[$];
	int         mismatch_count = 0;
	int         items_sent     = 0;
	int         cycle_count    = 0;
	// While set, neither the sender nor the receiver inserts idle cycles.
	bit         steady         = 1'b0;

	// Predictor state: the current arc position, the scaled decision value, the
	// region, whether the walk has ended, and the loaded ellipse.
	int         arc_x;
	int         arc_y;
	longint     arc_decision;
	bit         arc_region_two;
	bit         arc_done;
	int         ellipse_cx;
	int         ellipse_cy;
	longint     rx_sq;
	longint     ry_sq;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Moves the predicted walk one point along the first-quadrant arc. The decision
	// value is kept at four times its textbook value so that it stays an integer.
	function automatic void advance_arc();
		longint x;
		longint y;
		x = arc_x;
		y = arc_y;
		// Crossing into region two happens once the slope passes minus one; the
		// decision value is then recomputed for the midpoint below the current point.
		if (!arc_region_two && !(ry_sq * x <= rx_sq * y)) begin
			arc_decision = ry_sq * (2 * x + 1) * (2 * x + 1)
				+ 4 * rx_sq * (y - 1) * (y - 1) - 4 * rx_sq * ry_sq;
			arc_region_two = 1'b1;
		end
		if (!arc_region_two) begin
			x++;
			if (arc_decision < 0) begin
				arc_decision += 8 * ry_sq * x + 4 * ry_sq;
			end else begin
				y--;
				arc_decision += 8 * ry_sq * x - 8 * rx_sq * y + 4 * ry_sq;
			end
		end else begin
			y--;
			if (arc_decision > 0) begin
				arc_decision += -8 * rx_sq * y + 4 * rx_sq;
			end else begin
				x++;
				arc_decision += 8 * ry_sq * x - 8 * rx_sq * y + 4 * rx_sq;
			end
		end
		arc_x = int'(x);
		arc_y = int'(y);
		// The walk ends as soon as the y offset reaches zero, in either region.
		if (arc_y == 0) begin
			arc_done = 1'b1;
		end
	endfunction

	// Applies one accepted input transfer to the predictor and returns the point
	// that the block must report for it.
	function automatic arc_point_t predict_point(input logic act,
			input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input logic [RADIUS_W-1:0] rx, input logic [RADIUS_W-1:0] ry);
		arc_point_t pt;
		longint     r_x;
		longint     r_y;
		if (act == ACT_START) begin
			r_x            = rx;
			r_y            = ry;
			ellipse_cx     = cx;
			ellipse_cy     = cy;
			rx_sq          = r_x * r_x;
			ry_sq          = r_y * r_y;
			arc_x          = 0;
			arc_y          = int'(r_y);
			arc_region_two = 1'b0;
			arc_decision   = 4 * ry_sq - 4 * rx_sq * r_y + rx_sq;
			// A flat ellipse is a single point and is finished right away.
			arc_done       = (r_y == 0);
		end else if (!arc_done) begin
			advance_arc();
		end
		// An advance on a finished walk leaves the state alone and repeats the point.
		pt.right_x    = OUT_W'(ellipse_cx + arc_x);
		pt.left_x     = OUT_W'(ellipse_cx - arc_x);
		pt.top_y      = OUT_W'(ellipse_cy + arc_y);
		pt.bottom_y   = OUT_W'(ellipse_cy - arc_y);
		pt.last_point = (arc_y == 0);
		return pt;
	endfunction

	// Presents one input transfer at a falling edge, holds it until the block takes
	// it, and records the predicted point at the accepting rising edge.
	task automatic send_item(input logic act, input int cx, input int cy,
			input int rx, input int ry);
		if (!steady && $urandom_range(0, 99) < 32) begin
			repeat ($urandom_range(1, 12)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action   <= act;
		center_x <= COORD_W'(cx);
		center_y <= COORD_W'(cy);
		radius_x <= RADIUS_W'(rx);
		radius_y <= RADIUS_W'(ry);
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pending_points.push_back(predict_point(act, COORD_W'(cx), COORD_W'(cy),
			RADIUS_W'(rx), RADIUS_W'(ry)));
		items_sent++;
	endtask

	// An advance carries random center and radius fields, which the block ignores.
	task automatic send_advance();
		send_item(ACT_ADVANCE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
			$urandom_range(0, RADIUS_MAX), $urandom_range(0, RADIUS_MAX));
	endtask

	// Starts an ellipse and follows its arc for at most step_cap points, then sends
	// a number of further advances, which land on a finished walk if it ended.
	task automatic trace_ellipse(input int cx, input int cy, input int rx, input int ry,
			input int step_cap, input int extra);
		int steps;
		steps = 0;
		send_item(ACT_START, cx, cy, rx, ry);
		while (!arc_done && steps < step_cap) begin
			send_advance();
			steps++;
		end
		repeat (extra) begin
			send_advance();
		end
	endtask

	// Lowers valid and waits until every predicted point has been received.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_points.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// After reset the walk counts as finished at the point (0, 0), so an advance
	// returns that point with the end flag.
	task automatic test_advance_after_reset();
		send_advance();
		send_advance();
		wait_drain();
	endtask

	// Extremes of the center and radius fields, a flat ellipse, a zero horizontal
	// radius, a walk whose y offset reaches zero in region one, and a restart in
	// the middle of a walk.
	task automatic test_field_extremes();
		trace_ellipse(0, 0, 1, 1, 10, 1);
		trace_ellipse(COORD_MAX, COORD_MAX, RADIUS_MAX, RADIUS_MAX, 2, 0);
		trace_ellipse(512, 512, 0, 6, 20, 0);
		trace_ellipse(COORD_MAX, 0, 5, 0, 0, 1);
		trace_ellipse(0, COORD_MAX, RADIUS_MAX, 1, 3, 0);
		trace_ellipse(300, 700, 2, 3, 2, 0);
		wait_drain();
	endtask

	// Full-rate transfers on both sides across several complete small walks.
	task automatic test_back_to_back();
		steady = 1'b1;
		for (int i = 0; i < 8; i++) begin
			trace_ellipse($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
				$urandom_range(0, 15), $urandom_range(1, 15), 1000, i % 3);
		end
		trace_ellipse(40, 40, 12, 9, 5, 0);
		trace_ellipse(900, 20, 9, 12, 1000, 1);
		wait_drain();
		steady = 1'b0;
	endtask

	// The widest ellipse walked to its end drives the decision value and the
	// region-two restart to their largest magnitudes.
	task automatic test_largest_ellipse();
		trace_ellipse(COORD_MAX, COORD_MAX, RADIUS_MAX, RADIUS_MAX, 2000, 1);
		wait_drain();
	endtask

	// Mostly complete walks of random small ellipses; some medium ones cut short,
	// large starts with a few steps, and bursts of random transfers.
	task automatic test_random_walks();
		int sel;
		while (items_sent < ITEM_TARGET) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				trace_ellipse($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					$urandom_range(0, 24), $urandom_range(0, 24), 1000,
					$urandom_range(0, 2));
			end else if (sel < 82) begin
				trace_ellipse($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					$urandom_range(25, 120), $urandom_range(25, 120),
					$urandom_range(10, 200), 0);
			end else if (sel < 90) begin
				trace_ellipse($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					$urandom_range(0, RADIUS_MAX), $urandom_range(0, RADIUS_MAX),
					$urandom_range(5, 40), 0);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_item(logic'($urandom_range(0, 1)),
						$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
						$urandom_range(0, RADIUS_MAX), $urandom_range(0, RADIUS_MAX));
				end
			end
		end
		wait_drain();
	endtask

	// The receiver stalls at random, one decision per cycle at the falling edge.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 32);
	end

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// Every result transfer is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		arc_point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				$display("%0t ns: result expected none, got (%0d, %0d, %0d, %0d, %0b)",
					$time, right_x, left_x, top_y, bottom_y, last_point);
				mismatch_count++;
			end else begin
				want = pending_points.pop_front();
				check_field("right_x", want.right_x, right_x);
				check_field("left_x", want.left_x, left_x);
				check_field("top_y", want.top_y, top_y);
				check_field("bottom_y", want.bottom_y, bottom_y);
				check_field("last_point", want.last_point, last_point);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL midpoint_ellipse_rasterizer_unit");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		action    = ACT_START;
		center_x  = '0;
		center_y  = '0;
		radius_x  = '0;
		radius_y  = '0;
		out_stall = 1'b0;
		// The predictor starts from the reset state: a finished walk at (0, 0).
		void'(predict_point(ACT_START, '0, '0, '0, '0));
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_advance_after_reset();
		test_field_extremes();
		test_back_to_back();
		test_largest_ellipse();
		test_random_walks();

		// Give a stray extra result time to show up before the verdict.
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_points.size() == 0) begin
			$display("PASS midpoint_ellipse_rasterizer_unit");
		end else begin
			$display("FAIL midpoint_ellipse_rasterizer_unit");
		end
		$finish;
	end

endmodule
